// ----- rtl/core/obfd_pkg.sv -----
package obfd_pkg;

    // Width of one direction component at the input.
    localparam int unsigned IN_W = 31;
    // Width of one axis component at the output.
    localparam int unsigned AXIS_W = 14;
    // Three squares of 31-bit values stay below 2^62.
    localparam int unsigned SUM_W = 2 * IN_W;
    // Default number of fraction bits of the basis.
    localparam int unsigned FRAC_BITS_DEF = 12;

endpackage

// ----- rtl/core/obfd_sqrt.sv -----
module obfd_sqrt #(
    parameter int unsigned VW = 62,
    parameter int unsigned SW = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [VW-1:0]               in_val,
    input  logic [SW-1:0]               in_side,
    output logic                        out_vld,
    output logic [(VW+1)/2-1:0]         out_root,
    output logic [SW-1:0]               out_side
);

    localparam int unsigned RW = (VW + 1) / 2;
    localparam int unsigned TW = 2 * RW;

    logic [RW-1:0] vld_reg;
    logic [RW-1:0] q_reg    [RW];
    logic [TW-1:0] rem_reg  [RW];
    logic [SW-1:0] side_reg [RW];

    // One root bit per stage, most significant bit first.
    for (genvar s = 0; s < RW; s++) begin : g_step
        localparam int unsigned B = RW - 1 - s;

        logic          vld_p;
        logic [RW-1:0] q_p;
        logic [TW-1:0] rem_p;
        logic [SW-1:0] side_p;
        logic [TW-1:0] trial;
        logic          fits;
        logic [RW-1:0] q_next;
        logic [TW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign vld_p  = in_vld;
            assign q_p    = '0;
            assign rem_p  = TW'(in_val);
            assign side_p = in_side;
        end else begin : g_later
            assign vld_p  = vld_reg[s-1];
            assign q_p    = q_reg[s-1];
            assign rem_p  = rem_reg[s-1];
            assign side_p = side_reg[s-1];
        end

        // The partial root has no bits at or below B, so the OR is an add.
        assign trial    = (TW'(q_p) << (B + 1)) | (TW'(1) << (2 * B));
        assign fits     = rem_p >= trial;
        assign q_next   = fits ? (q_p | (RW'(1) << B)) : q_p;
        assign rem_next = fits ? (rem_p - trial) : rem_p;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s]    <= q_next;
                rem_reg[s]  <= rem_next;
                side_reg[s] <= side_p;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = q_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

// ----- rtl/core/orthonormal_basis_from_direction.sv -----
// Builds a fixed-point rotation basis (right, up, forward) from a signed direction vector.
// Forward is the direction scaled to unit length, right is (-fwd_z, 0, fwd_x) renormalized,
// or (1, 0, 0) for a direction along y, and up is forward cross right. A zero direction
// gives valid_res low and all axes zero. The block takes one transfer per cycle while the
// output is not stalled. Its pipeline holds one stage per bit of the 31-bit length root,
// then one stage per quotient bit of the forward division, one per bit of the right-axis
// root and one per quotient bit of the right-axis division.
module orthonormal_basis_from_direction #(
    parameter int unsigned FRAC_BITS = obfd_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                dir_valid,
    output logic                                dir_ready,
    input  logic signed [obfd_pkg::IN_W-1:0]    dir_x,
    input  logic signed [obfd_pkg::IN_W-1:0]    dir_y,
    input  logic signed [obfd_pkg::IN_W-1:0]    dir_z,
    output logic                                basis_valid,
    input  logic                                basis_ready,
    output logic                                valid_res,
    output logic signed [obfd_pkg::AXIS_W-1:0]  right_x,
    output logic signed [obfd_pkg::AXIS_W-1:0]  right_y,
    output logic signed [obfd_pkg::AXIS_W-1:0]  right_z,
    output logic signed [obfd_pkg::AXIS_W-1:0]  up_x,
    output logic signed [obfd_pkg::AXIS_W-1:0]  up_y,
    output logic signed [obfd_pkg::AXIS_W-1:0]  up_z,
    output logic signed [obfd_pkg::AXIS_W-1:0]  fwd_x,
    output logic signed [obfd_pkg::AXIS_W-1:0]  fwd_y,
    output logic signed [obfd_pkg::AXIS_W-1:0]  fwd_z
);

    import obfd_pkg::*;

    localparam int unsigned F   = FRAC_BITS;
    localparam int unsigned QB  = F + 1;
    localparam int unsigned FW  = F + 2;
    localparam int unsigned NW  = IN_W + F;
    localparam int unsigned SQW = 2 * QB;
    localparam int unsigned RNW = 2 * F + 1;
    localparam int unsigned PW  = 2 * FW;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << F;
    localparam logic signed [FW-1:0] ONE_F = FW'(1) << F;

    typedef struct packed {
        logic                     zero;
        logic [2:0]               neg;
        logic [2:0][IN_W-1:0]     mag;
    } side1_t;

    typedef struct packed {
        logic                     zero;
        logic                     rz;
        logic [1:0]               rneg;
        logic [2:0][FW-1:0]       f;
    } rinfo_t;

    typedef struct packed {
        rinfo_t                   info;
        logic [1:0][QB-1:0]       m;
    } side2_t;

    logic en;
    logic h_vld_reg;

    // The whole pipeline moves together; it holds only while a result waits.
    assign en        = !h_vld_reg || basis_ready;
    assign dir_ready = en;

    // Stage A: magnitudes, signs and squares.
    logic signed [IN_W-1:0] din [3];
    logic [IN_W-1:0]        mag_next [3];
    logic                   a_vld_reg;
    logic [IN_W-1:0]        a_mag_reg [3];
    logic [2:0]             a_neg_reg;
    logic [SUM_W-1:0]       a_sq_reg  [3];

    assign din[0] = dir_x;
    assign din[1] = dir_y;
    assign din[2] = dir_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k] = din[k][IN_W-1] ? IN_W'(~din[k] + 1'b1) : IN_W'(din[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= dir_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_mag_reg[k] <= mag_next[k];
                a_neg_reg[k] <= din[k][IN_W-1];
                a_sq_reg[k]  <= SUM_W'(mag_next[k]) * SUM_W'(mag_next[k]);
            end
        end
    end

    // Stage B: squared length.
    logic             b_vld_reg;
    logic [SUM_W-1:0] b_len2_reg;
    side1_t           b_side_reg;
    logic [SUM_W-1:0] len2_next;

    assign len2_next = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_len2_reg      <= len2_next;
            b_side_reg.zero <= len2_next == '0;
            b_side_reg.neg  <= a_neg_reg;
            for (int k = 0; k < 3; k++)
            begin
                b_side_reg.mag[k] <= a_mag_reg[k];
            end
        end
    end

    // Length root.
    logic                 s1_vld;
    logic [IN_W-1:0]      s1_root;
    logic [$bits(side1_t)-1:0] s1_side_bits;
    side1_t               s1_side;

    obfd_sqrt #(
        .VW (SUM_W),
        .SW ($bits(side1_t))
    ) u_len_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (b_vld_reg),
        .in_val   (b_len2_reg),
        .in_side  (b_side_reg),
        .out_vld  (s1_vld),
        .out_root (s1_root),
        .out_side (s1_side_bits)
    );

    assign s1_side = side1_t'(s1_side_bits);

    // Forward division: |d| << F by the length, one quotient bit per stage.
    logic [QB-1:0]   fd_vld_reg;
    logic [NW-1:0]   fd_rem_reg  [QB][3];
    logic [QB-1:0]   fd_q_reg    [QB][3];
    logic [IN_W-1:0] fd_len_reg  [QB];
    logic [2:0]      fd_neg_reg  [QB];
    logic [QB-1:0]   fd_zero_reg;

    for (genvar t = 0; t < QB; t++) begin : g_fdiv
        localparam int unsigned B = QB - 1 - t;

        logic            vld_p;
        logic [NW-1:0]   rem_p [3];
        logic [QB-1:0]   q_p   [3];
        logic [IN_W-1:0] len_p;
        logic [2:0]      neg_p;
        logic            zero_p;
        logic [NW-1:0]   trial;
        logic [NW-1:0]   rem_next [3];
        logic [QB-1:0]   q_next   [3];

        if (t == 0) begin : g_first
            always_comb
            begin
                vld_p  = s1_vld;
                len_p  = s1_root;
                neg_p  = s1_side.neg;
                zero_p = s1_side.zero;
                for (int k = 0; k < 3; k++)
                begin
                    rem_p[k] = NW'(s1_side.mag[k]) << F;
                    q_p[k]   = '0;
                end
            end
        end else begin : g_later
            always_comb
            begin
                vld_p  = fd_vld_reg[t-1];
                len_p  = fd_len_reg[t-1];
                neg_p  = fd_neg_reg[t-1];
                zero_p = fd_zero_reg[t-1];
                for (int k = 0; k < 3; k++)
                begin
                    rem_p[k] = fd_rem_reg[t-1][k];
                    q_p[k]   = fd_q_reg[t-1][k];
                end
            end
        end

        assign trial = NW'(len_p) << B;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (rem_p[k] >= trial)
                begin
                    rem_next[k] = rem_p[k] - trial;
                    q_next[k]   = q_p[k] | (QB'(1) << B);
                end
                else
                begin
                    rem_next[k] = rem_p[k];
                    q_next[k]   = q_p[k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fd_vld_reg[t] <= 1'b0;
            end
            else if (en)
            begin
                fd_vld_reg[t] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    fd_rem_reg[t][k] <= rem_next[k];
                    fd_q_reg[t][k]   <= q_next[k];
                end
                fd_len_reg[t]  <= len_p;
                fd_neg_reg[t]  <= neg_p;
                fd_zero_reg[t] <= zero_p;
            end
        end
    end

    // Stage C: signed forward axis, and squares of the right-axis seed.
    // Right starts as (-fwd_z, 0, fwd_x), so its magnitudes are the z and x quotients.
    logic [QB-1:0]          fq [3];
    logic [2:0]             fneg;
    logic                   c_vld_reg;
    logic signed [FW-1:0]   c_f_reg  [3];
    logic [SQW-1:0]         c_sq_reg [2];
    logic [QB-1:0]          c_m_reg  [2];
    logic [1:0]             c_rneg_reg;
    logic                   c_rz_reg;
    logic                   c_zero_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fq[k] = fd_q_reg[QB-1][k];
        end
        fneg = fd_neg_reg[QB-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= fd_vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_f_reg[k] <= fneg[k] ? -$signed(FW'(fq[k])) : $signed(FW'(fq[k]));
            end
            c_sq_reg[0]   <= SQW'(fq[2]) * SQW'(fq[2]);
            c_sq_reg[1]   <= SQW'(fq[0]) * SQW'(fq[0]);
            c_m_reg[0]    <= fq[2];
            c_m_reg[1]    <= fq[0];
            c_rneg_reg[0] <= !fneg[2];
            c_rneg_reg[1] <= fneg[0];
            c_rz_reg      <= (fq[0] == '0) && (fq[2] == '0);
            c_zero_reg    <= fd_zero_reg[QB-1];
        end
    end

    // Right-axis length root.
    side2_t                     c_side;
    logic [SQW-1:0]             c_sum;
    logic                       s2_vld;
    logic [QB-1:0]              s2_root;
    logic [$bits(side2_t)-1:0]  s2_side_bits;
    side2_t                     s2_side;

    always_comb
    begin
        c_side.info.zero = c_zero_reg;
        c_side.info.rz   = c_rz_reg;
        c_side.info.rneg = c_rneg_reg;
        for (int k = 0; k < 3; k++)
        begin
            c_side.info.f[k] = c_f_reg[k];
        end
        c_side.m[0] = c_m_reg[0];
        c_side.m[1] = c_m_reg[1];
    end

    assign c_sum = c_sq_reg[0] + c_sq_reg[1];

    obfd_sqrt #(
        .VW (SQW),
        .SW ($bits(side2_t))
    ) u_right_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_vld_reg),
        .in_val   (c_sum),
        .in_side  (c_side),
        .out_vld  (s2_vld),
        .out_root (s2_root),
        .out_side (s2_side_bits)
    );

    assign s2_side = side2_t'(s2_side_bits);

    // Right-axis division, two lanes sharing the root.
    logic [QB-1:0]  rd_vld_reg;
    logic [RNW-1:0] rd_rem_reg [QB][2];
    logic [QB-1:0]  rd_q_reg   [QB][2];
    logic [QB-1:0]  rd_len_reg [QB];
    rinfo_t         rd_info_reg [QB];

    for (genvar t = 0; t < QB; t++) begin : g_rdiv
        localparam int unsigned B = QB - 1 - t;

        logic           vld_p;
        logic [RNW-1:0] rem_p [2];
        logic [QB-1:0]  q_p   [2];
        logic [QB-1:0]  len_p;
        rinfo_t         info_p;
        logic [RNW-1:0] trial;
        logic [RNW-1:0] rem_next [2];
        logic [QB-1:0]  q_next   [2];

        if (t == 0) begin : g_first
            always_comb
            begin
                vld_p  = s2_vld;
                len_p  = s2_root;
                info_p = s2_side.info;
                for (int k = 0; k < 2; k++)
                begin
                    rem_p[k] = RNW'(s2_side.m[k]) << F;
                    q_p[k]   = '0;
                end
            end
        end else begin : g_later
            always_comb
            begin
                vld_p  = rd_vld_reg[t-1];
                len_p  = rd_len_reg[t-1];
                info_p = rd_info_reg[t-1];
                for (int k = 0; k < 2; k++)
                begin
                    rem_p[k] = rd_rem_reg[t-1][k];
                    q_p[k]   = rd_q_reg[t-1][k];
                end
            end
        end

        assign trial = RNW'(len_p) << B;

        always_comb
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (rem_p[k] >= trial)
                begin
                    rem_next[k] = rem_p[k] - trial;
                    q_next[k]   = q_p[k] | (QB'(1) << B);
                end
                else
                begin
                    rem_next[k] = rem_p[k];
                    q_next[k]   = q_p[k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rd_vld_reg[t] <= 1'b0;
            end
            else if (en)
            begin
                rd_vld_reg[t] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    rd_rem_reg[t][k] <= rem_next[k];
                    rd_q_reg[t][k]   <= q_next[k];
                end
                rd_len_reg[t]  <= len_p;
                rd_info_reg[t] <= info_p;
            end
        end
    end

    // Stage E: signed right axis; a direction along y takes (1, 0, 0).
    rinfo_t               rinfo;
    logic signed [FW-1:0] rdiv [2];
    logic                 e_vld_reg;
    logic signed [FW-1:0] e_f_reg [3];
    logic signed [FW-1:0] e_r0_reg;
    logic signed [FW-1:0] e_r2_reg;
    logic                 e_zero_reg;

    assign rinfo = rd_info_reg[QB-1];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rdiv[k] = rinfo.rneg[k] ? -$signed(FW'(rd_q_reg[QB-1][k]))
                                    : $signed(FW'(rd_q_reg[QB-1][k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= rd_vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_f_reg[k] <= $signed(rinfo.f[k]);
            end
            e_r0_reg   <= rinfo.rz ? ONE_F : rdiv[0];
            e_r2_reg   <= rinfo.rz ? '0 : rdiv[1];
            e_zero_reg <= rinfo.zero;
        end
    end

    // Stage G: cross-product terms (right_y is always zero).
    logic                 g_vld_reg;
    logic signed [PW-1:0] g_p_reg [4];
    logic signed [FW-1:0] g_f_reg [3];
    logic signed [FW-1:0] g_r0_reg;
    logic signed [FW-1:0] g_r2_reg;
    logic                 g_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            g_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_p_reg[0] <= e_f_reg[1] * e_r2_reg;
            g_p_reg[1] <= e_f_reg[2] * e_r0_reg;
            g_p_reg[2] <= e_f_reg[0] * e_r2_reg;
            g_p_reg[3] <= e_f_reg[1] * e_r0_reg;
            for (int k = 0; k < 3; k++)
            begin
                g_f_reg[k] <= e_f_reg[k];
            end
            g_r0_reg   <= e_r0_reg;
            g_r2_reg   <= e_r2_reg;
            g_zero_reg <= e_zero_reg;
        end
    end

    // Stage H: output register.
    logic signed [PW:0]   u_full [3];
    logic                 valid_res_reg;
    logic signed [AXIS_W-1:0] right_x_reg;
    logic signed [AXIS_W-1:0] right_z_reg;
    logic signed [AXIS_W-1:0] up_reg  [3];
    logic signed [AXIS_W-1:0] fwd_reg [3];

    always_comb
    begin
        u_full[0] = (PW + 1)'(g_p_reg[0]) >>> F;
        u_full[1] = ((PW + 1)'(g_p_reg[1]) - (PW + 1)'(g_p_reg[2])) >>> F;
        u_full[2] = (-(PW + 1)'(g_p_reg[3])) >>> F;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_res_reg <= !g_zero_reg;
            right_x_reg   <= g_zero_reg ? '0 : AXIS_W'(g_r0_reg);
            right_z_reg   <= g_zero_reg ? '0 : AXIS_W'(g_r2_reg);
            for (int k = 0; k < 3; k++)
            begin
                up_reg[k]  <= g_zero_reg ? '0 : AXIS_W'(u_full[k]);
                fwd_reg[k] <= g_zero_reg ? '0 : AXIS_W'(g_f_reg[k]);
            end
        end
    end

    assign basis_valid = h_vld_reg;
    assign valid_res   = valid_res_reg;
    assign right_x     = right_x_reg;
    assign right_y     = '0;
    assign right_z     = right_z_reg;
    assign up_x        = up_reg[0];
    assign up_y        = up_reg[1];
    assign up_z        = up_reg[2];
    assign fwd_x       = fwd_reg[0];
    assign fwd_y       = fwd_reg[1];
    assign fwd_z       = fwd_reg[2];

`ifndef SYNTH
    // A component never exceeds the length, so each forward quotient is at most one.
    a_fwd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fd_vld_reg[QB-1] && !fd_zero_reg[QB-1] |->
            fd_q_reg[QB-1][0] <= ONE_Q && fd_q_reg[QB-1][1] <= ONE_Q &&
            fd_q_reg[QB-1][2] <= ONE_Q)
        else $error("forward quotient above one");

    a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg[QB-1] && !rinfo.zero && !rinfo.rz |->
            rd_q_reg[QB-1][0] <= ONE_Q && rd_q_reg[QB-1][1] <= ONE_Q)
        else $error("right quotient above one");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        basis_valid && !valid_res |->
            fwd_x == '0 && fwd_y == '0 && fwd_z == '0 && right_x == '0 &&
            right_z == '0 && up_x == '0 && up_y == '0 && up_z == '0)
        else $error("zero direction with nonzero axes");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        g_vld_reg && !en |=> g_vld_reg && $stable(g_p_reg[1]))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- bench/basis_checker.sv -----
module basis_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               dir_valid,
    input  logic                               dir_ready,
    input  logic signed [obfd_pkg::IN_W-1:0]   dir_x,
    input  logic signed [obfd_pkg::IN_W-1:0]   dir_y,
    input  logic signed [obfd_pkg::IN_W-1:0]   dir_z,
    input  logic                               basis_valid,
    input  logic                               basis_ready,
    input  logic                               valid_res,
    input  logic signed [obfd_pkg::AXIS_W-1:0] right_x,
    input  logic signed [obfd_pkg::AXIS_W-1:0] right_y,
    input  logic signed [obfd_pkg::AXIS_W-1:0] right_z,
    input  logic signed [obfd_pkg::AXIS_W-1:0] up_x,
    input  logic signed [obfd_pkg::AXIS_W-1:0] up_y,
    input  logic signed [obfd_pkg::AXIS_W-1:0] up_z,
    input  logic signed [obfd_pkg::AXIS_W-1:0] fwd_x,
    input  logic signed [obfd_pkg::AXIS_W-1:0] fwd_y,
    input  logic signed [obfd_pkg::AXIS_W-1:0] fwd_z,
    output int                                 errors,
    output int                                 pending
);
    localparam int FB = obfd_pkg::FRAC_BITS_DEF;
    localparam int AW = obfd_pkg::AXIS_W;

    typedef logic [9*AW:0] basis_t;

    basis_t expected_bases[$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic basis_t build_basis(longint dx, longint dy, longint dz);
        longint one;
        longint f[3];
        longint r[3];
        longint u[3];
        longint unsigned len2;
        longint unsigned len;
        longint unsigned rl;
        basis_t b;
        one = longint'(1) << FB;
        len2 = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        if (len2 == 0)
            return '0;
        len = root_floor(len2);
        f[0] = (dx * one) / longint'(len);
        f[1] = (dy * one) / longint'(len);
        f[2] = (dz * one) / longint'(len);
        r[0] = -f[2];
        r[1] = 0;
        r[2] = f[0];
        if (r[0] == 0 && r[2] == 0)
            r[0] = one;
        else
        begin
            rl = root_floor(r[0] * r[0] + r[2] * r[2]);
            r[0] = (r[0] * one) / longint'(rl);
            r[2] = (r[2] * one) / longint'(rl);
        end
        // The shift on a signed longint is arithmetic, so it floors.
        u[0] = (f[1] * r[2] - f[2] * r[1]) >>> FB;
        u[1] = (f[2] * r[0] - f[0] * r[2]) >>> FB;
        u[2] = (f[0] * r[1] - f[1] * r[0]) >>> FB;
        b = {1'b1, r[0][AW-1:0], r[1][AW-1:0], r[2][AW-1:0],
             u[0][AW-1:0], u[1][AW-1:0], u[2][AW-1:0],
             f[0][AW-1:0], f[1][AW-1:0], f[2][AW-1:0]};
        return b;
    endfunction

    basis_t seen;
    basis_t want;

    assign pending = expected_bases.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dir_valid && dir_ready)
                expected_bases.push_back(build_basis(dir_x, dir_y, dir_z));
            if (basis_valid && basis_ready)
            begin
                seen = {valid_res, right_x, right_y, right_z, up_x, up_y, up_z,
                        fwd_x, fwd_y, fwd_z};
                if (expected_bases.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected basis transfer: %h", seen);
                end
                else
                begin
                    want = expected_bases.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("basis mismatch: expected %h actual %h", want, seen);
                    end
                end
            end
        end
    end
endmodule

// ----- bench/orthonormal_basis_from_direction_test.sv -----
module orthonormal_basis_from_direction_test;
    localparam int IW = obfd_pkg::IN_W;
    localparam int LAT = 3 * obfd_pkg::FRAC_BITS_DEF + 40;

    logic clk;
    logic rst_n;
    logic dir_valid;
    logic dir_ready;
    logic signed [IW-1:0] dir_x, dir_y, dir_z;
    logic basis_valid;
    logic basis_ready;
    logic valid_res;
    logic signed [obfd_pkg::AXIS_W-1:0] right_x, right_y, right_z;
    logic signed [obfd_pkg::AXIS_W-1:0] up_x, up_y, up_z;
    logic signed [obfd_pkg::AXIS_W-1:0] fwd_x, fwd_y, fwd_z;
    int errors;
    int pending;
    int cycles;
    bit calm;
    bit long_hold;

    orthonormal_basis_from_direction dut (.*);

    basis_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off that fills the pipeline.
    initial
    begin
        int n;
        basis_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                basis_ready <= 0;
                repeat (LAT + 60) @(posedge clk);
                long_hold = 0;
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                basis_ready <= 0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge clk);
            end
            basis_ready <= 1;
        end
    end

    function automatic logic [IW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return IW'($urandom_range(0, 8) - 4);
            1: return IW'($urandom_range(0, 8191) - 4096);
            2: return IW'({1'b1, {(IW-1){1'b0}}} + $urandom_range(0, 3));
            3: return IW'({1'b0, {(IW-1){1'b1}}} - $urandom_range(0, 3));
            default: return IW'($urandom());
        endcase
    endfunction

    task automatic send(input logic [IW-1:0] x, input logic [IW-1:0] y,
                        input logic [IW-1:0] z);
        dir_valid <= 1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        do
            @(posedge clk);
        while (!dir_ready);
    endtask

    initial
    begin
        logic [IW-1:0] mn;
        logic [IW-1:0] mx;
        int n;
        mn = {1'b1, {(IW-1){1'b0}}};
        mx = {1'b0, {(IW-1){1'b1}}};
        rst_n = 0;
        dir_valid = 0;
        dir_x = 0;
        dir_y = 0;
        dir_z = 0;
        calm = 0;
        long_hold = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(0, 0, 0);
        send(0, 1, 0);
        send(0, -1, 0);
        send(0, mx, 0);
        send(0, mn, 0);
        send(1, 0, 0);
        send(0, 0, -1);
        send(mx, mx, mx);
        send(mn, mn, mn);
        send(mn, mx, mn);
        send(mx, 0, mn);
        send(1, 1, 1);
        send(-1, -1, -1);
        send(3, 1000000, -2);
        send(1, mx, 1);
        send(-7, 5, 3);
        send(mn, 1, 0);
        send(0, 0, mx);
        // Hold the output while the sender keeps offering.
        long_hold = 1;
        for (int i = 0; i < 1040; i++)
        begin
            if (i == 500)
            begin
                dir_valid <= 0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (i == 900)
                calm = 1;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                dir_valid <= 0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge clk);
            end
            send(rand_comp(), rand_comp(), rand_comp());
        end
        dir_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
